// ===== sv/pnm_pkg.sv =====
// ----------------------------------------------------------------------------
// pnm_pkg
// Shared constants and byte-class functions for the pnm stream decoder.
// ----------------------------------------------------------------------------
package pnm_pkg;

  localparam int unsigned DimBits        = 14;
  localparam int unsigned AccBits        = 17;
  localparam int unsigned ValBits        = 16;

  localparam logic [1:0] KindPixel  = 2'd0;
  localparam logic [1:0] KindHeader = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  localparam logic [2:0] ErrNone    = 3'd0;
  localparam logic [2:0] ErrMagic   = 3'd1;
  localparam logic [2:0] ErrDigit   = 3'd2;
  localparam logic [2:0] ErrZero    = 3'd3;
  localparam logic [2:0] ErrToken   = 3'd4;
  localparam logic [2:0] ErrTooBig  = 3'd5;

  localparam logic [2:0] FmtAsciiBit  = 3'd0;
  localparam logic [2:0] FmtAsciiGray = 3'd1;
  localparam logic [2:0] FmtAsciiRgb  = 3'd2;
  localparam logic [2:0] FmtRawBit    = 3'd3;
  localparam logic [2:0] FmtRawGray   = 3'd4;
  localparam logic [2:0] FmtRawRgb    = 3'd5;

  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch1    = 8'h31;
  localparam logic [7:0] Ch6    = 8'h36;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [AccBits-1:0] AccMax = 17'h1ffff;

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= Ch0) && (b <= Ch9);
  endfunction

endpackage

// ===== sv/pnm_scaler.sv =====
// ----------------------------------------------------------------------------
// pnm_scaler
// Iterative restoring divider: 255*v/maxval, one quotient bit per cycle; gives 255 when v exceeds maxval.
// ----------------------------------------------------------------------------
module pnm_scaler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pnm_pkg::AccBits-1:0] value_i,
  input  logic [pnm_pkg::ValBits-1:0] maxval_i,
  output logic                       done_o,
  output logic [7:0]                 level_o
);
  import pnm_pkg::*;

  // quotient is below 256 once v <= maxval, so 8 steps suffice
  logic [24:0] prod255;
  logic [7:0]  lo_q, lo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [7:0]  quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;
  logic [15:0] m;

  assign m = (maxval_i == '0) ? 16'd1 : maxval_i;

  always_comb begin
    lo_d = lo_q; rem_d = rem_q; div_d = div_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0; prod255 = '0;
    if (start_i) begin
      div_d = m;
      if (value_i > {1'b0, m}) begin
        quo_d = 8'hff; done_d = 1'b1;
      end else begin
        // 255*v = (v<<8) - v, first rem holds the top bits above the 8 we shift in
        prod255 = 25'({value_i, 8'h00}) - 25'(value_i);
        lo_d = prod255[7:0];
        rem_d = prod255[24:8];
        quo_d = '0; cnt_d = 4'd8; busy_d = 1'b1;
      end
    end else if (busy_q) begin
      trial = {rem_q[15:0], lo_q[3'(cnt_q - 4'd1)]};
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[6:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[6:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; rem_q <= rem_d; div_q <= div_d; quo_q <= quo_d;
  end

  assign done_o  = done_q;
  assign level_o = quo_q;
endmodule

// ===== sv/pnm_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// pnm_stream_decoder
// Byte-serial netpbm decoder, P1 to P6, emitting header, pixel and error items.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  s_axis   in   tdata: data_byte[7:0]; tuser: file_start
//  m_axis   out  tdata: kind..last_of_image packed; tlast: last_of_run
//
//  one byte at a time; not ready until all its results are handed over
//  scaled samples: the byte or number runs through the divider, and the next byte
//  is taken once the divider is done and any pixel that it gives is handed over
//  raw bitmap bytes give up to 8 pixels, one per output transaction
//  async active-low reset returns the parser to waiting for the magic byte
module pnm_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // file_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kind[1:0] error_code[4:2] format[7:5] image_width[21:8] image_height[35:22]
  // red[43:36] green[51:44] blue[59:52] column[73:60] row[87:74]
  // last_of_image[88], zero pad to 96
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_of_run
);
  import pnm_pkg::*;

  typedef enum logic [3:0] {
    PhMagic, PhDigit, PhWidth, PhHeight, PhMaxval, PhData, PhDone, PhError
  } phase_e;
  typedef enum logic [2:0] {
    StIdle, StScale, StBits, StOut
  } state_e;

  localparam logic [AccBits-1:0] DimMax = AccBits'((1 << DimBits) - 1);

  phase_e ph_q, ph_d;
  state_e st_q, st_d;
  logic [2:0] fmt_q, fmt_d;
  logic [13:0] w_q, w_d, h_q, h_d, col_q, col_d, row_q, row_d;
  logic [15:0] mx_q, mx_d;
  logic [AccBits-1:0] acc_q, acc_d;
  logic tok_q, tok_d, cmt_q, cmt_d;
  logic [1:0] ch_q, ch_d;
  logic [7:0] hr_q, hr_d, hg_q, hg_d;
  logic [7:0] byte_q, byte_d;
  logic [3:0] bit_q, bit_d;
  logic [95:0] od_q, od_d;
  logic ov_q, ov_d, ol_q, ol_d;
  logic sc_start;
  logic [AccBits-1:0] sc_val;
  logic sc_done;
  logic [7:0] sc_lvl;

  pnm_scaler u_scaler (
    .clk_i, .rst_ni, .start_i(sc_start), .value_i(sc_val), .maxval_i(mx_q),
    .done_o(sc_done), .level_o(sc_lvl)
  );

  always_comb begin : main
    logic [7:0] b;
    logic [AccBits+3:0] prod;
    logic [13:0] nc, nr;
    logic lastimg, bitmore;
    logic [1:0] kind;
    logic [2:0] ec;
    logic [7:0] pr, pg, pb;
    logic emit, done_byte, fin;
    logic [AccBits-1:0] v;
    ph_d = ph_q; st_d = st_q; fmt_d = fmt_q; w_d = w_q; h_d = h_q;
    col_d = col_q; row_d = row_q; mx_d = mx_q; acc_d = acc_q; tok_d = tok_q;
    cmt_d = cmt_q; ch_d = ch_q; hr_d = hr_q; hg_d = hg_q; byte_d = byte_q;
    bit_d = bit_q; od_d = od_q; ov_d = ov_q; ol_d = ol_q;
    sc_start = 1'b0; sc_val = '0;
    b = s_axis_tdata; prod = '0; v = '0;
    emit = 1'b0; done_byte = 1'b0; fin = 1'b0;
    kind = KindPixel; ec = ErrNone; pr = '0; pg = '0; pb = '0;
    nc = '0; nr = '0; lastimg = 1'b0; bitmore = 1'b0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (s_axis_tvalid && !ov_q) begin
          if (s_axis_tuser) begin
            ph_d = PhMagic; fmt_d = '0; w_d = '0; h_d = '0; mx_d = '0;
            acc_d = '0; tok_d = 1'b0; cmt_d = 1'b0; col_d = '0; row_d = '0;
            ch_d = '0; hr_d = '0; hg_d = '0;
          end
          byte_d = b;
          case (s_axis_tuser ? PhMagic : ph_q)
            PhMagic: begin
              if (b == ChP) ph_d = PhDigit;
              else begin emit = 1'b1; kind = KindError; ec = ErrMagic; end
            end
            PhDigit: begin
              if (b >= Ch1 && b <= Ch6) begin
                fmt_d = 3'(b - Ch1); ph_d = PhWidth;
              end else begin emit = 1'b1; kind = KindError; ec = ErrDigit; end
            end
            PhWidth, PhHeight, PhMaxval: begin
              if (cmt_q) begin
                if (b == ChLf) cmt_d = 1'b0;
              end else if (is_digit(b)) begin
                prod = 21'(acc_q) * 21'd10 + 21'(b - Ch0);
                acc_d = (prod > 21'(AccMax)) ? AccMax : AccBits'(prod);
                tok_d = 1'b1;
              end else if (is_space(b)) begin
                if (tok_q) begin
                  tok_d = 1'b0; acc_d = '0; v = acc_q;
                  if (v == '0) begin emit = 1'b1; kind = KindError; ec = ErrZero; end
                  else if (ph_q != PhMaxval && v > DimMax) begin
                    emit = 1'b1; kind = KindError; ec = ErrTooBig;
                  end else if (ph_q == PhMaxval && v > 17'hffff) begin
                    emit = 1'b1; kind = KindError; ec = ErrTooBig;
                  end else if (ph_q == PhWidth) begin
                    w_d = 14'(v); ph_d = PhHeight;
                  end else begin
                    if (ph_q == PhHeight) h_d = 14'(v); else mx_d = 16'(v);
                    if (ph_q == PhHeight && !(fmt_q == FmtAsciiBit ||
                        fmt_q == FmtRawBit)) ph_d = PhMaxval;
                    else begin
                      ph_d = PhData; col_d = '0; row_d = '0; ch_d = '0;
                      emit = 1'b1; kind = KindHeader;
                    end
                  end
                end
              end else if (b == ChHash && !tok_q) cmt_d = 1'b1;
              else begin emit = 1'b1; kind = KindError; ec = ErrToken; end
            end
            PhData: begin
              if (fmt_q == FmtAsciiBit) begin
                if (cmt_q) begin
                  if (b == ChLf) cmt_d = 1'b0;
                end else if (b == Ch0 || b == Ch1) begin
                  fin = 1'b1; pr = (b == Ch0) ? 8'hff : 8'h00; pg = pr; pb = pr;
                end else if (b == ChHash) cmt_d = 1'b1;
                else if (!is_space(b)) begin
                  emit = 1'b1; kind = KindError; ec = ErrToken;
                end
              end else if (fmt_q == FmtRawBit) begin
                bit_d = 4'd7; st_d = StBits;
              end else if (fmt_q == FmtRawGray || fmt_q == FmtRawRgb) begin
                sc_start = 1'b1; sc_val = AccBits'(b); st_d = StScale;
              end else begin
                if (cmt_q) begin
                  if (b == ChLf) cmt_d = 1'b0;
                end else if (is_digit(b)) begin
                  prod = 21'(acc_q) * 21'd10 + 21'(b - Ch0);
                  acc_d = (prod > 21'(AccMax)) ? AccMax : AccBits'(prod);
                  tok_d = 1'b1;
                end else if (is_space(b)) begin
                  if (tok_q) begin
                    tok_d = 1'b0; acc_d = '0;
                    sc_start = 1'b1; sc_val = acc_q; st_d = StScale;
                  end
                end else if (b == ChHash && !tok_q) cmt_d = 1'b1;
                else begin emit = 1'b1; kind = KindError; ec = ErrToken; end
              end
            end
            default: ;
          endcase
          if (emit && kind == KindError) ph_d = PhError;
          done_byte = 1'b1;
        end
      end
      StScale: begin
        if (sc_done) begin
          done_byte = 1'b1;
          if (fmt_q == FmtAsciiGray || fmt_q == FmtRawGray) begin
            fin = 1'b1; pr = sc_lvl; pg = sc_lvl; pb = sc_lvl;
          end else if (ch_q == 2'd0) begin hr_d = sc_lvl; ch_d = 2'd1; end
          else if (ch_q == 2'd1) begin hg_d = sc_lvl; ch_d = 2'd2; end
          else begin
            ch_d = 2'd0; fin = 1'b1; pr = hr_q; pg = hg_q; pb = sc_lvl;
          end
          st_d = StIdle;
        end
      end
      StBits: begin
        if (!ov_q || m_axis_tready) begin
          pr = byte_q[bit_q[2:0]] ? 8'h00 : 8'hff; pg = pr; pb = pr;
          fin = 1'b1;
          bitmore = 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
    if (fin) begin
      nc = col_q + 14'd1; nr = row_q;
      if (nc >= w_q) begin
        nc = '0; nr = row_q + 14'd1;
        if (nr >= h_q) begin lastimg = 1'b1; ph_d = PhDone; end
      end
      col_d = nc; row_d = nr;
      emit = 1'b1; kind = KindPixel;
    end
    if (emit) begin
      ov_d = 1'b1;
      // raw bitmap: stop at end of row or after the last bit
      ol_d = bitmore ? (bit_q == 4'd0 || nr != row_q) : 1'b1;
      od_d = '0;
      // header fields as they stand after this byte
      od_d[1:0] = kind; od_d[4:2] = ec; od_d[7:5] = fmt_d;
      od_d[21:8] = w_d; od_d[35:22] = h_d;
      od_d[43:36] = pr; od_d[51:44] = pg; od_d[59:52] = pb;
      od_d[73:60] = fin ? col_q : 14'd0; od_d[87:74] = fin ? row_q : 14'd0;
      od_d[88] = lastimg;
      if (bitmore) begin
        if (ol_d) st_d = StIdle; else bit_d = bit_q - 4'd1;
      end
    end
    if (done_byte && !bitmore && st_d == StIdle) st_d = StIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhMagic; st_q <= StIdle; fmt_q <= '0; w_q <= '0; h_q <= '0;
      col_q <= '0; row_q <= '0; mx_q <= '0; acc_q <= '0; tok_q <= 1'b0;
      cmt_q <= 1'b0; ch_q <= '0; hr_q <= '0; hg_q <= '0; ov_q <= 1'b0;
      ol_q <= 1'b0; bit_q <= '0;
    end else begin
      ph_q <= ph_d; st_q <= st_d; fmt_q <= fmt_d; w_q <= w_d; h_q <= h_d;
      col_q <= col_d; row_q <= row_d; mx_q <= mx_d; acc_q <= acc_d;
      tok_q <= tok_d; cmt_q <= cmt_d; ch_q <= ch_d; hr_q <= hr_d;
      hg_q <= hg_d; ov_q <= ov_d; ol_q <= ol_d; bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d; od_q <= od_d;
  end

  assign s_axis_tready = (st_q == StIdle) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for pnm_stream_decoder: byte streams of whole and broken
// PNM files, a cycle-free decoder model that predicts every header, pixel and
// error transaction, and a field-by-field scoreboard on the master side.
// ----------------------------------------------------------------------------
module tb_top;
  import pnm_pkg::*;

  localparam int unsigned WdogLimit = 20000;

  typedef enum logic [2:0] {
    PhMagic, PhDigit, PhWidth, PhHeight, PhMaxval, PhData, PhDone, PhError
  } phase_e;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } file_byte_t;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [2:0]  fmt;
    logic [13:0] width;
    logic [13:0] height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [13:0] col;
    logic [13:0] row;
    logic        last_run;
    logic        last_img;
  } decoded_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte[7:0]
  logic        s_axis_tuser = 1'b0; // file_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // kind, error_code, format, width, height, rgb,
                                    // column, row, last_of_image
  logic        m_axis_tlast;        // last_of_run

  pnm_stream_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  file_byte_t pending_bytes[$];
  decoded_t   expected_items[$];
  decoded_t   step_items[$];
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  int         fail_count = 0;
  int         quiet_cycles = 0;
  bit         byte_fire = 1'b0;
  bit         next_start = 1'b0;

  // decoder model state
  phase_e      ph;
  logic [2:0]  img_fmt;
  int unsigned width_q, height_q, maxval_q, acc_q;
  bit          in_token, in_comment;
  int unsigned col_q, row_q, chan_q;
  logic [7:0]  held_r, held_g;

  function automatic bit ws_byte(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  task automatic model_reset();
    ph = PhMagic; img_fmt = FmtAsciiBit;
    width_q = 0; height_q = 0; maxval_q = 0; acc_q = 0;
    in_token = 0; in_comment = 0;
    col_q = 0; row_q = 0; chan_q = 0; held_r = 0; held_g = 0;
  endtask

  task automatic emit(input logic [1:0] kind, input logic [2:0] err,
                      input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                      input int unsigned col, input int unsigned row, input bit li);
    decoded_t d;
    d.kind = kind; d.err = err; d.fmt = img_fmt;
    d.width = width_q[13:0]; d.height = height_q[13:0];
    d.red = r; d.green = g; d.blue = b;
    d.col = col[13:0]; d.row = row[13:0];
    d.last_run = 1'b0; d.last_img = li;
    if (step_items.size() < 8) step_items.push_back(d);
  endtask

  task automatic flag_error(input logic [2:0] code);
    emit(KindError, code, 0, 0, 0, 0, 0, 0);
    ph = PhError;
  endtask

  task automatic put_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned col, row;
    bit li;
    col = col_q; row = row_q; li = 0;
    col_q++;
    if (col_q >= width_q) begin
      col_q = 0;
      row_q++;
      if (row_q >= height_q) begin
        li = 1;
        ph = PhDone;
      end
    end
    emit(KindPixel, ErrNone, r, g, b, col, row, li);
  endtask

  function automatic logic [7:0] scale_level(input int unsigned v);
    int unsigned m;
    m = (maxval_q != 0) ? maxval_q : 1;
    if (v > m) return 8'hff;
    return 8'((255 * v) / m);
  endfunction

  task automatic put_sample(input logic [7:0] lv);
    if (img_fmt == FmtAsciiGray || img_fmt == FmtRawGray) begin
      put_pixel(lv, lv, lv);
    end else if (chan_q == 0) begin
      held_r = lv; chan_q = 1;
    end else if (chan_q == 1) begin
      held_g = lv; chan_q = 2;
    end else begin
      chan_q = 0;
      put_pixel(held_r, held_g, lv);
    end
  endtask

  // 0 nothing, 1 number complete, -1 bad token
  function automatic int number_char(input logic [7:0] b, output int unsigned val);
    int unsigned a;
    val = 0;
    if (in_comment) begin
      if (b == ChLf) in_comment = 0;
      return 0;
    end
    if (b >= Ch0 && b <= Ch9) begin
      a = acc_q * 10 + (b - Ch0);
      acc_q = (a > 32'h1ffff) ? 32'h1ffff : a;
      in_token = 1;
      return 0;
    end
    if (ws_byte(b)) begin
      if (in_token) begin
        in_token = 0;
        val = acc_q;
        acc_q = 0;
        return 1;
      end
      return 0;
    end
    if (b == ChHash && !in_token) begin
      in_comment = 1;
      return 0;
    end
    return -1;
  endfunction

  task automatic header_complete();
    ph = PhData; col_q = 0; row_q = 0; chan_q = 0;
    emit(KindHeader, ErrNone, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic header_char(input logic [7:0] b);
    int unsigned v;
    int r;
    r = number_char(b, v);
    if (r < 0) begin
      flag_error(ErrToken);
    end else if (r > 0) begin
      if (v == 0) begin
        flag_error(ErrZero);
      end else if (ph == PhWidth || ph == PhHeight) begin
        if (v > 16383) begin
          flag_error(ErrTooBig);
        end else if (ph == PhWidth) begin
          width_q = v; ph = PhHeight;
        end else begin
          height_q = v;
          if (img_fmt == FmtAsciiBit || img_fmt == FmtRawBit) header_complete();
          else ph = PhMaxval;
        end
      end else if (v > 65535) begin
        flag_error(ErrTooBig);
      end else begin
        maxval_q = v;
        header_complete();
      end
    end
  endtask

  task automatic image_char(input logic [7:0] b);
    int unsigned v, row0;
    logic [7:0] mask, lv;
    int r;
    if (img_fmt == FmtAsciiBit) begin
      if (in_comment) begin
        if (b == ChLf) in_comment = 0;
      end else if (b == Ch0) begin
        put_pixel(8'hff, 8'hff, 8'hff);
      end else if (b == Ch1) begin
        put_pixel(8'h00, 8'h00, 8'h00);
      end else if (b == ChHash) begin
        in_comment = 1;
      end else if (!ws_byte(b)) begin
        flag_error(ErrToken);
      end
    end else if (img_fmt == FmtRawBit) begin
      // msb first, rest of the byte is row padding
      mask = 8'h80;
      row0 = row_q;
      while (mask != 0 && ph == PhData && row_q == row0) begin
        lv = (b & mask) ? 8'h00 : 8'hff;
        put_pixel(lv, lv, lv);
        mask = mask >> 1;
      end
    end else if (img_fmt == FmtRawGray || img_fmt == FmtRawRgb) begin
      put_sample(scale_level(b));
    end else begin
      r = number_char(b, v);
      if (r < 0) flag_error(ErrToken);
      else if (r > 0) put_sample(scale_level(v));
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic start);
    if (start) model_reset();
    case (ph)
      PhMagic: begin
        if (b == ChP) ph = PhDigit;
        else flag_error(ErrMagic);
      end
      PhDigit: begin
        if (b >= Ch1 && b <= Ch6) begin
          img_fmt = 3'(b - Ch1);
          ph = PhWidth;
        end else begin
          flag_error(ErrDigit);
        end
      end
      PhWidth, PhHeight, PhMaxval: header_char(b);
      PhData: image_char(b);
      default: ;
    endcase
    if (step_items.size() > 0) step_items[step_items.size()-1].last_run = 1'b1;
    foreach (step_items[i]) expected_items.push_back(step_items[i]);
    step_items.delete();
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic push_byte(input logic [7:0] d);
    file_byte_t fb;
    fb.data = d; fb.start = next_start;
    next_start = 0;
    pending_bytes.push_back(fb);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  task automatic push_ws();
    logic [7:0] opts[6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    push_byte(opts[$urandom_range(5)]);
  endtask

  // whitespace, sometimes a comment with random content
  task automatic push_gap();
    logic [7:0] c;
    push_ws();
    if ($urandom_range(3) == 0) push_ws();
    if ($urandom_range(4) == 0) begin
      push_byte(ChHash);
      repeat ($urandom_range(3)) begin
        c = 8'($urandom);
        push_byte(c == ChLf ? 8'h41 : c);
      end
      push_byte(ChLf);
    end
  endtask

  task automatic push_file(input string s);
    next_start = 1;
    push_text(s);
  endtask

  task automatic gen_image(input int f, input int w, input int h, input int mv,
                           input bit tail);
    int n, nch;
    int unsigned v;
    next_start = 1;
    push_byte(ChP);
    push_byte(8'(Ch1 + f));
    push_gap();
    push_text($sformatf("%0d", w));
    push_gap();
    push_text($sformatf("%0d", h));
    if (f != 0 && f != 3) begin
      push_gap();
      push_text($sformatf("%0d", mv));
    end
    if (f >= 3) push_ws();
    else push_gap();
    nch = (f == 2 || f == 5) ? 3 : 1;
    n = w * h * nch;
    case (f)
      0: repeat (w * h) begin
        push_byte($urandom_range(1) ? Ch1 : Ch0);
        if ($urandom_range(2) == 0) push_gap();
      end
      1, 2: repeat (n) begin
        v = ($urandom_range(4) == 0) ? $urandom_range(mv + 5, mv) : $urandom_range(mv);
        push_text($sformatf("%0d", v));
        push_gap();
      end
      3: repeat (h * ((w + 7) / 8)) push_byte(8'($urandom));
      default: repeat (n) push_byte(8'($urandom));
    endcase
    if (tail) repeat ($urandom_range(3, 1)) push_byte(8'($urandom));
  endtask

  task automatic random_image();
    int f, w, h, mv, first, k;
    f = $urandom_range(5);
    w = (f == 3) ? $urandom_range(12, 1) : $urandom_range(5, 1);
    h = $urandom_range(3, 1);
    case ($urandom_range(3))
      0: mv = 1;
      1: mv = 255;
      2: mv = 65535;
      default: mv = $urandom_range(300, 1);
    endcase
    first = pending_bytes.size();
    gen_image(f, w, h, mv, $urandom_range(3) == 0);
    // a fifth of the files get one byte trashed
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(pending_bytes.size() - 1, first);
      pending_bytes[k].data = 8'($urandom);
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_items.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || byte_fire) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes[0].data;
          s_axis_tuser  <= pending_bytes[0].start;
          void'(pending_bytes.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------- monitor and scoreboard ----------------
  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    decoded_t e;
    byte_fire = 1'b0;
    if (rst_ni) begin
      quiet_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        byte_fire = 1'b1;
        quiet_cycles = 0;
        predict_byte(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        if (expected_items.size() == 0) begin
          $error("unexpected output transaction, tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          e = expected_items.pop_front();
          check_field("kind", e.kind, m_axis_tdata[1:0]);
          check_field("error_code", e.err, m_axis_tdata[4:2]);
          check_field("format", e.fmt, m_axis_tdata[7:5]);
          check_field("image_width", e.width, m_axis_tdata[21:8]);
          check_field("image_height", e.height, m_axis_tdata[35:22]);
          check_field("red_level", e.red, m_axis_tdata[43:36]);
          check_field("green_level", e.green, m_axis_tdata[51:44]);
          check_field("blue_level", e.blue, m_axis_tdata[59:52]);
          check_field("pixel_column", e.col, m_axis_tdata[73:60]);
          check_field("pixel_row", e.row, m_axis_tdata[87:74]);
          check_field("last_of_run", e.last_run, m_axis_tlast);
          check_field("last_of_image", e.last_img, m_axis_tdata[88]);
        end
      end
      if (quiet_cycles >= WdogLimit) begin
        $display("pnm_stream_decoder verification failed");
        $finish;
      end
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    int src_pcts[4] = '{0, 71, 0, 10};
    int snk_pcts[4] = '{0, 0, 71, 10};
    model_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // one small image per format, then header corner cases and errors
    gen_image(0, 3, 2, 1, 1);
    gen_image(1, 2, 1, 1, 0);
    gen_image(2, 1, 2, 65535, 0);
    gen_image(3, 9, 2, 1, 1);
    gen_image(4, 2, 2, 255, 0);
    gen_image(5, 1, 1, 7, 0);
    push_file("P4 16383 1\n");
    push_byte(8'hff);
    push_file("P6 1 16383 65535\n");
    push_byte(8'h00);
    push_file("X");
    push_file("P7");
    push_file("P0");
    push_file("P1 0 ");
    push_file("P2 3 -1");
    push_file("P2 3#x");
    push_file("P1 16384 ");
    push_file("P5 2 2 65536 ");
    push_file("P3 1 1 0 ");
    push_file("P1 2 2 1 2");
    push_file("P1 99999999 ");
    push_file("P9xyz");
    drain();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pcts[p];
      snk_stall_pct = snk_pcts[p];
      while (pending_bytes.size() < 40) random_image();
      drain();
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && expected_items.size() == 0) begin
      $display("pnm_stream_decoder verification clean");
    end else begin
      $display("pnm_stream_decoder verification failed");
    end
    $finish;
  end

endmodule
